### rtl/ydf_pkg.sv
// ----------------------------------------------------------------------------
// ydf_pkg
// Shared widths, register indexes, reset values and the control types passed
// between the sequencer, the cell row and the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package ydf_pkg;

    // Field widths fixed by the block's interface
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int LAG_W     = 7;
    localparam int FRAME_W   = 32;
    localparam int DIFF_W    = 38;

    // Parameter defaults
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration reset values
    localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd64;
    localparam logic [CFG_W-1:0] HOP_RESET    = 7'd16;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE = 2'd0,
        REG_HOP_SIZE    = 2'd1
    } ydf_reg_t;

    // Rotation of one work chain in the cell row
    typedef enum logic [1:0] {
        MOVE_HOLD,
        MOVE_UP,
        MOVE_DOWN
    } ydf_move_t;

    // Control for every cell of the row
    typedef struct packed {
        logic      shift_in;
        logic      load;
        ydf_move_t x_move;
        ydf_move_t y_move;
    } ydf_chain_ctl_t;

    // One sample pair handed to the accumulate pipeline
    typedef struct packed {
        logic               valid;
        logic               first_pair;
        logic               last_pair;
        logic               last_lag;
        logic [LAG_W-1:0]   lag;
        logic [FRAME_W-1:0] frame;
    } ydf_issue_t;

    // Frame sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ALIGN,
        ST_SWEEP
    } ydf_state_t;

endpackage

### rtl/ydf_if.sv
// ----------------------------------------------------------------------------
// ydf_if
// Valid/ready channels: the sample input and the difference result output.
// ----------------------------------------------------------------------------
interface ydf_sample_if #(
    parameter int SAMPLE_BITS = ydf_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ydf_result_if;
    import ydf_pkg::*;

    logic               valid;
    logic               ready;
    logic [LAG_W-1:0]   lag;
    logic [FRAME_W-1:0] frame_index;
    logic [DIFF_W-1:0]  diff_value;
    logic               last_lag;

    modport source (output valid, output lag, output frame_index, output diff_value,
                    output last_lag, input ready);
    modport sink   (input valid, input lag, input frame_index, input diff_value,
                    input last_lag, output ready);
endinterface

### rtl/ydf_cell.sv
// ----------------------------------------------------------------------------
// ydf_cell
// One position of the sample row: a history register that shifts with each
// accepted word, and two work registers that rotate in either direction.
// ----------------------------------------------------------------------------
module ydf_cell #(
    parameter int SAMPLE_BITS = ydf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  ydf_pkg::ydf_chain_ctl_t       ctl,
    input  logic signed [SAMPLE_BITS-1:0] a_lower,
    input  logic signed [SAMPLE_BITS-1:0] x_lower,
    input  logic signed [SAMPLE_BITS-1:0] x_upper,
    input  logic signed [SAMPLE_BITS-1:0] y_lower,
    input  logic signed [SAMPLE_BITS-1:0] y_upper,
    output logic signed [SAMPLE_BITS-1:0] a_value,
    output logic signed [SAMPLE_BITS-1:0] x_value,
    output logic signed [SAMPLE_BITS-1:0] y_value
);
    import ydf_pkg::*;

    logic signed [SAMPLE_BITS-1:0] a_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;

    // Advance the history line by one position
    always_ff @(posedge clk)
    begin
        if (ctl.shift_in)
        begin
            a_reg <= a_lower;
        end
    end

    // Copy the history into the first work chain, or rotate it
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg <= a_reg;
        end
        else
        begin
            case (ctl.x_move)
                MOVE_UP:   x_reg <= x_lower;
                MOVE_DOWN: x_reg <= x_upper;
                default:   x_reg <= x_reg;
            endcase
        end
    end

    // Copy the history into the second work chain, or rotate it
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            y_reg <= a_reg;
        end
        else
        begin
            case (ctl.y_move)
                MOVE_UP:   y_reg <= y_lower;
                MOVE_DOWN: y_reg <= y_upper;
                default:   y_reg <= y_reg;
            endcase
        end
    end

    assign a_value = a_reg;
    assign x_value = x_reg;
    assign y_value = y_reg;

endmodule

### rtl/ydf_chain.sv
// ----------------------------------------------------------------------------
// ydf_chain
// Row of 2*MAX_WINDOW cells. The history enters at cell 0; the work chains
// close into rings, and both are read at cell 0.
// ----------------------------------------------------------------------------
module ydf_chain #(
    parameter int MAX_WINDOW  = ydf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = ydf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  ydf_pkg::ydf_chain_ctl_t       ctl,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0] x_tap,
    output logic signed [SAMPLE_BITS-1:0] y_tap
);
    import ydf_pkg::*;

    localparam int N = 2 * MAX_WINDOW;

    logic signed [SAMPLE_BITS-1:0] a_w [N];
    logic signed [SAMPLE_BITS-1:0] x_w [N];
    logic signed [SAMPLE_BITS-1:0] y_w [N];

    // Build the row, wrapping the work chains end to end
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        localparam int LOWER_IDX = (i == 0) ? N - 1 : i - 1;
        localparam int UPPER_IDX = (i == N - 1) ? 0 : i + 1;

        ydf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .a_lower ((i == 0) ? sample_in : a_w[LOWER_IDX]),
            .x_lower (x_w[LOWER_IDX]),
            .x_upper (x_w[UPPER_IDX]),
            .y_lower (y_w[LOWER_IDX]),
            .y_upper (y_w[UPPER_IDX]),
            .a_value (a_w[i]),
            .x_value (x_w[i]),
            .y_value (y_w[i])
        );
    end

    assign x_tap = x_w[0];
    assign y_tap = y_w[0];

endmodule

### rtl/ydf_mac.sv
// ----------------------------------------------------------------------------
// ydf_mac
// Difference, square and accumulate over the pairs of one lag, with the
// result register in front of the output channel.
// ----------------------------------------------------------------------------
module ydf_mac #(
    parameter int SAMPLE_BITS = ydf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ydf_pkg::ydf_issue_t           issue,
    input  logic signed [SAMPLE_BITS-1:0] x_tap,
    input  logic signed [SAMPLE_BITS-1:0] y_tap,
    output logic                          advance,
    ydf_result_if.source                  results
);
    import ydf_pkg::*;

    localparam int SQ_W  = 2 * (SAMPLE_BITS + 1);
    localparam int EXT_W = (SQ_W > DIFF_W) ? SQ_W : DIFF_W;

    ydf_issue_t                  s1_reg;
    logic signed [SAMPLE_BITS:0] diff_reg;
    logic [DIFF_W-1:0]           acc_reg;
    logic signed [SQ_W-1:0]      sq;
    logic [EXT_W-1:0]            sq_ext;
    logic [DIFF_W-1:0]           sum;

    logic                        out_valid_reg;
    logic [LAG_W-1:0]            out_lag_reg;
    logic [FRAME_W-1:0]          out_frame_reg;
    logic [DIFF_W-1:0]           out_diff_reg;
    logic                        out_last_reg;

    // Move everything only when the result register can take a word
    assign advance = !out_valid_reg || results.ready;

    // Square the difference and add it to the running sum
    assign sq     = diff_reg * diff_reg;
    assign sq_ext = EXT_W'($unsigned(sq));
    assign sum    = (s1_reg.first_pair ? '0 : acc_reg) + sq_ext[DIFF_W-1:0];

    // Difference stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else if (advance)
        begin
            s1_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            diff_reg <= {x_tap[SAMPLE_BITS-1], x_tap} - {y_tap[SAMPLE_BITS-1], y_tap};
        end
    end

    // Accumulate stage
    always_ff @(posedge clk)
    begin
        if (advance && s1_reg.valid)
        begin
            acc_reg <= sum;
        end
    end

    // Result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_reg.valid && s1_reg.last_pair;
        end
    end

    // Capture the finished sum of a lag
    always_ff @(posedge clk)
    begin
        if (advance && s1_reg.valid && s1_reg.last_pair)
        begin
            out_lag_reg   <= s1_reg.lag;
            out_frame_reg <= s1_reg.frame;
            out_diff_reg  <= sum;
            out_last_reg  <= s1_reg.last_lag;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.lag         = out_lag_reg;
    assign results.frame_index = out_frame_reg;
    assign results.diff_value  = out_diff_reg;
    assign results.last_lag    = out_last_reg;

endmodule

### rtl/yin_difference_function.sv
// ----------------------------------------------------------------------------
// yin_difference_function
// Streaming squared-difference function over a sliding window of samples.
// ----------------------------------------------------------------------------
// A sample that does not complete a frame is taken while the sequencer is
// idle. A sample that completes a frame starts a sweep of the two rotating
// work chains past one multiply-accumulate unit, one sample pair per cycle
// while the result channel does not hold it back. W is the window and
// L = floor(W/hop)*hop; samples are refused until the sweep has issued its
// last pair. Results of a frame leave one per lag in increasing lag order,
// each passing the difference stage and the result register after the last
// pair of its lag. After reset and after any write to the window or hop
// register, input is held off while L is found by adding the hop repeatedly.
module yin_difference_function #(
    parameter int MAX_WINDOW  = ydf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = ydf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [ydf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ydf_pkg::CFG_W-1:0]      cfg_data,
    ydf_sample_if.sink                     samples,
    ydf_result_if.source                   results
);
    import ydf_pkg::*;

    localparam int N     = 2 * MAX_WINDOW;
    localparam int POS_W = $clog2(N);
    localparam int AW    = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;
    localparam logic [AW-1:0] MAX_W_A = AW'(MAX_WINDOW);

    // Configuration
    logic [CFG_W-1:0] win_cfg_reg;
    logic [CFG_W-1:0] hop_cfg_reg;
    logic             win_we;
    logic             hop_we;
    logic             cfg_hit;
    logic [AW-1:0]    win_ext;
    logic [AW-1:0]    hop_ext;
    logic [AW-1:0]    w_eff;
    logic [AW-1:0]    h_eff;

    // Frame length
    logic [AW-1:0]    len_reg;
    logic             len_done_reg;
    logic [AW-1:0]    len_sum;
    logic [AW-1:0]    span_m1;
    logic [AW-1:0]    centre;

    // Framing counters
    logic [AW-1:0]      fill_reg;
    logic [AW-1:0]      fill_next;
    logic [AW-1:0]      fill_inc;
    logic [CFG_W-1:0]   hop_reg;
    logic [CFG_W-1:0]   hop_next;
    logic [CFG_W:0]     hop_inc;
    logic [FRAME_W-1:0] frame_reg;
    logic               emit;
    logic               in_ready;
    logic               in_acc;

    // Sequencer
    ydf_state_t         state_reg;
    ydf_state_t         state_next;
    logic [POS_W-1:0]   ox_reg;
    logic [POS_W-1:0]   oy_reg;
    logic [POS_W-1:0]   ox_next;
    logic [POS_W-1:0]   oy_next;
    logic [AW-1:0]      p_reg;
    logic [LAG_W-1:0]   lag_reg;
    logic [AW-1:0]      start_reg;
    logic [FRAME_W-1:0] frame_cur_reg;
    logic [AW-1:0]      lo_pos;
    logic [AW-1:0]      tx;
    logic [AW-1:0]      ty;
    logic               sweep_down;
    logic               aligned;
    logic               pair_last;
    logic               lag_last;
    logic               advance;

    ydf_chain_ctl_t                ctl;
    ydf_issue_t                    issue;
    logic signed [SAMPLE_BITS-1:0] x_tap;
    logic signed [SAMPLE_BITS-1:0] y_tap;

    // Decode register writes
    always_comb
    begin
        win_we = 1'b0;
        hop_we = 1'b0;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE: win_we = 1'b1;
                REG_HOP_SIZE:    hop_we = 1'b1;
                default:         ;
            endcase
        end
    end

    assign cfg_hit = win_we || hop_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_cfg_reg <= WINDOW_RESET;
            hop_cfg_reg <= HOP_RESET;
        end
        else
        begin
            if (win_we)
            begin
                win_cfg_reg <= cfg_data;
            end
            if (hop_we)
            begin
                hop_cfg_reg <= cfg_data;
            end
        end
    end

    // Clamp window and hop to their working ranges
    assign win_ext = AW'(win_cfg_reg);
    assign hop_ext = AW'(hop_cfg_reg);
    assign w_eff   = (win_ext < AW'(2)) ? AW'(2) : ((win_ext > MAX_W_A) ? MAX_W_A : win_ext);
    assign h_eff   = (hop_ext == '0) ? AW'(1) : ((hop_ext > w_eff) ? w_eff : hop_ext);

    // Find the frame length by adding hops while they fit in the window
    assign len_sum = len_reg + h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            len_done_reg <= 1'b0;
        end
        else if (cfg_hit)
        begin
            len_reg      <= '0;
            len_done_reg <= 1'b0;
        end
        else if (!len_done_reg)
        begin
            if (len_sum <= w_eff)
            begin
                len_reg <= len_sum;
            end
            else
            begin
                len_done_reg <= 1'b1;
            end
        end
    end

    assign span_m1 = w_eff + len_reg - AW'(1);
    assign centre  = (w_eff + AW'(1)) >> 1;

    // Count samples up to the first frame, then frame every hop
    assign in_acc   = samples.valid && in_ready;
    assign fill_inc = fill_reg + AW'(1);
    assign hop_inc  = {1'b0, hop_reg} + (CFG_W + 1)'(1);

    always_comb
    begin
        emit      = 1'b0;
        fill_next = fill_reg;
        hop_next  = hop_reg;
        if (fill_reg < span_m1)
        begin
            fill_next = fill_inc;
            if (fill_inc == span_m1)
            begin
                hop_next = CFG_W'(h_eff - AW'(1));
            end
        end
        else if (AW'(hop_inc) >= h_eff)
        begin
            emit     = 1'b1;
            hop_next = '0;
        end
        else
        begin
            hop_next = CFG_W'(hop_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            hop_reg  <= '0;
        end
        else if (cfg_hit)
        begin
            fill_reg <= '0;
            hop_reg  <= '0;
        end
        else if (in_acc)
        begin
            fill_reg <= fill_next;
            hop_reg  <= hop_next;
        end
    end

    // Sweep targets for the current lag
    assign sweep_down = lag_reg[0];
    assign lo_pos     = w_eff - start_reg;
    assign tx         = sweep_down ? lo_pos : (lo_pos + len_reg - AW'(1));
    assign ty         = tx - AW'(lag_reg);
    assign aligned    = (AW'(ox_reg) == tx) && (AW'(oy_reg) == ty);
    assign pair_last  = (p_reg == len_reg - AW'(1));
    assign lag_last   = (AW'(lag_reg) == w_eff);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && emit)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (advance)
                begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN:
            begin
                if (advance && aligned)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (advance && pair_last)
                begin
                    state_next = lag_last ? ST_IDLE : ST_ALIGN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ready         = 1'b0;
        ctl              = '0;
        issue            = '0;
        issue.first_pair = (p_reg == '0);
        issue.last_pair  = pair_last;
        issue.last_lag   = lag_last;
        issue.lag        = lag_reg;
        issue.frame      = frame_cur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = len_done_reg;
                ctl.shift_in = samples.valid && len_done_reg;
            end
            ST_LOAD:
            begin
                ctl.load = advance;
            end
            ST_ALIGN:
            begin
                if (advance)
                begin
                    if (AW'(ox_reg) < tx)
                    begin
                        ctl.x_move = MOVE_DOWN;
                    end
                    else if (AW'(ox_reg) > tx)
                    begin
                        ctl.x_move = MOVE_UP;
                    end
                    if (AW'(oy_reg) < ty)
                    begin
                        ctl.y_move = MOVE_DOWN;
                    end
                    else if (AW'(oy_reg) > ty)
                    begin
                        ctl.y_move = MOVE_UP;
                    end
                end
            end
            ST_SWEEP:
            begin
                issue.valid = 1'b1;
                if (advance && !pair_last)
                begin
                    ctl.x_move = sweep_down ? MOVE_DOWN : MOVE_UP;
                    ctl.y_move = sweep_down ? MOVE_DOWN : MOVE_UP;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign samples.ready = in_ready;

    // Track which history position sits at the tap of each work chain
    always_comb
    begin
        case (ctl.x_move)
            MOVE_UP:   ox_next = ox_reg - POS_W'(1);
            MOVE_DOWN: ox_next = ox_reg + POS_W'(1);
            default:   ox_next = ox_reg;
        endcase
        case (ctl.y_move)
            MOVE_UP:   oy_next = oy_reg - POS_W'(1);
            MOVE_DOWN: oy_next = oy_reg + POS_W'(1);
            default:   oy_next = oy_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ox_reg    <= '0;
            oy_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.load)
            begin
                ox_reg <= '0;
                oy_reg <= '0;
            end
            else
            begin
                ox_reg <= ox_next;
                oy_reg <= oy_next;
            end
        end
    end

    // Frame, lag and pair counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg         <= '0;
            lag_reg       <= '0;
            start_reg     <= '0;
            frame_cur_reg <= '0;
            frame_reg     <= '0;
        end
        else if (cfg_hit)
        begin
            frame_reg <= '0;
        end
        else if (advance)
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    p_reg         <= '0;
                    lag_reg       <= LAG_W'(1);
                    start_reg     <= centre - AW'(1);
                    frame_cur_reg <= frame_reg;
                    frame_reg     <= frame_reg + FRAME_W'(1);
                end
                ST_SWEEP:
                begin
                    if (!pair_last)
                    begin
                        p_reg <= p_reg + AW'(1);
                    end
                    else
                    begin
                        p_reg   <= '0;
                        lag_reg <= lag_reg + LAG_W'(1);
                        // pairs move one step outward on every odd lag
                        if (!lag_reg[0])
                        begin
                            start_reg <= start_reg - AW'(1);
                        end
                    end
                end
                default:
                begin
                    p_reg <= p_reg;
                end
            endcase
        end
    end

    // Cell row
    ydf_chain #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_chain (
        .clk       (clk),
        .ctl       (ctl),
        .sample_in (samples.sample),
        .x_tap     (x_tap),
        .y_tap     (y_tap)
    );

    // Multiply-accumulate and result register
    ydf_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .x_tap   (x_tap),
        .y_tap   (y_tap),
        .advance (advance),
        .results (results)
    );

endmodule
